// ===== design/fcpa_pkg.sv =====
// Shared constants, codes and types of the fixed chunk pool allocator.
package fcpa_pkg;

  // Pool geometry.
  localparam int NUM_CHUNKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Saturation limit of the stack length counter.
  localparam logic [CNT_W-1:0] LEN_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] CHUNK_BYTES_RST = 16'd64;
  localparam logic [CNT_W-1:0]  CHUNK_COUNT_RST = CNT_W'(NUM_CHUNKS);

  // Command codes.
  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_FREE     = 2'd1;
  localparam logic [1:0] CMD_FREE_ALL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // Register select, taken from paddr bit 2.
  localparam logic REG_CHUNK_BYTES = 1'b0;
  localparam logic REG_CHUNK_COUNT = 1'b1;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fcpa_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
  } fcpa_ctl_t;

endpackage

// ===== design/fcpa_ctrl.sv =====
// Controller of the fixed chunk pool allocator: request sequencing and output valid.
module fcpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output fcpa_pkg::fcpa_ctl_t ctl
);
  import fcpa_pkg::*;

  fcpa_state_t state;
  fcpa_state_t state_next;
  logic        out_valid_next;
  logic        commit;

  // A held request completes once the output register is free or being drained.
  assign commit = (state == S_EXEC) && (!out_valid || out_ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_ready   = 1'b0;
    ctl.accept = 1'b0;
    ctl.commit = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_EXEC: begin
        ctl.commit = commit;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // The output register stays full until the receiver takes the transaction.
  always_comb begin
    out_valid_next = out_valid;
    if (commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/fcpa_datapath.sv =====
// Datapath of the fixed chunk pool allocator: link memory, list state and result register.
module fcpa_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  fcpa_pkg::fcpa_ctl_t           ctl,
  input  logic [1:0]                    cmd,
  input  logic [fcpa_pkg::SIZE_W-1:0]   request_bytes,
  input  logic [fcpa_pkg::IDX_W-1:0]    free_index,
  input  logic                          cfg_we,
  input  logic                          cfg_sel,
  input  logic [fcpa_pkg::DATA_W-1:0]   cfg_wdata,
  output logic [fcpa_pkg::SIZE_W-1:0]   chunk_bytes,
  output logic [fcpa_pkg::CNT_W-1:0]    chunk_count,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::IDX_W-1:0]    granted_index
);
  import fcpa_pkg::*;

  // Held request.
  logic [1:0]        cmd_q;
  logic [SIZE_W-1:0] req_q;
  logic [IDX_W-1:0]  idx_q;

  // Link memory and its registered read port.
  logic [IDX_W-1:0]  link_mem [0:NUM_CHUNKS-1];
  logic [IDX_W-1:0]  rd_link;

  // Free list state.
  logic [IDX_W-1:0]  list_top;
  logic              list_nonempty;
  logic [CNT_W-1:0]  list_length;
  logic [CNT_W-1:0]  untouched_left;

  logic [IDX_W-1:0]  list_top_next;
  logic              list_nonempty_next;
  logic [CNT_W-1:0]  list_length_next;
  logic [CNT_W-1:0]  untouched_left_next;
  logic [CNT_W-1:0]  untouched_dec;
  logic [CNT_W-1:0]  live_count;
  logic              range_err;
  logic              push;
  logic [1:0]        status_next;
  logic [IDX_W-1:0]  grant_next;

  // Chunks in use never exceed the size of the link memory.
  assign live_count = (chunk_count > CNT_W'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS) : chunk_count;
  assign range_err  = ({1'b0, idx_q} >= live_count);
  assign untouched_dec = untouched_left - CNT_W'(1);
  assign push = ctl.commit && (cmd_q == CMD_FREE) && !range_err;

  // Request decode and list update.
  always_comb begin
    list_top_next       = list_top;
    list_nonempty_next  = list_nonempty;
    list_length_next    = list_length;
    untouched_left_next = untouched_left;
    status_next         = ST_OK;
    grant_next          = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        if (req_q > chunk_bytes) begin
          status_next = ST_TOO_BIG;
        end else if (list_nonempty) begin
          // Pop the top of the stack; its link was read when the request was taken.
          grant_next    = list_top;
          list_top_next = rd_link;
          if (list_length != '0) list_length_next = list_length - CNT_W'(1);
          list_nonempty_next = (list_length_next != '0);
        end else if (untouched_left != '0) begin
          // Hand out the next untouched chunk, counting down.
          untouched_left_next = untouched_dec;
          grant_next          = untouched_dec[IDX_W-1:0];
        end else begin
          status_next = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (range_err) begin
          status_next = ST_RANGE;
        end else begin
          list_top_next = idx_q;
          if (list_length != LEN_MAX) list_length_next = list_length + CNT_W'(1);
          list_nonempty_next = 1'b1;
        end
      end
      CMD_FREE_ALL: begin
        list_top_next       = '0;
        list_nonempty_next  = 1'b0;
        list_length_next    = '0;
        untouched_left_next = live_count;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q <= cmd;
      req_q <= request_bytes;
      idx_q <= free_index;
    end
  end

  // Link memory: pushes write, accepted requests read the link under the top.
  always_ff @(posedge clk) begin
    if (push) begin
      link_mem[idx_q] <= list_top;
    end
    if (ctl.accept) begin
      rd_link <= link_mem[list_top];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status        <= status_next;
      granted_index <= grant_next;
    end
  end

  // Free list state.
  always_ff @(posedge clk) begin
    if (rst) begin
      list_top       <= '0;
      list_nonempty  <= 1'b0;
      list_length    <= '0;
      untouched_left <= CHUNK_COUNT_RST;
    end else if (ctl.commit) begin
      list_top       <= list_top_next;
      list_nonempty  <= list_nonempty_next;
      list_length    <= list_length_next;
      untouched_left <= untouched_left_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= CHUNK_BYTES_RST;
      chunk_count <= CHUNK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_CHUNK_BYTES: chunk_bytes <= cfg_wdata[SIZE_W-1:0];
        REG_CHUNK_COUNT: chunk_count <= cfg_wdata[CNT_W-1:0];
        default: chunk_bytes <= chunk_bytes;
      endcase
    end
  end

endmodule

// ===== design/fixed_chunk_pool_allocator.sv =====
// Top level of the fixed chunk pool allocator: ports, register port and assertions.
//
// Usage: a request transaction carries cmd (allocate, free one chunk, free all)
// with request_bytes and free_index; each request yields exactly one result
// transaction with status and granted_index, in request order.
// Both channels use valid/ready; a transaction moves when both are high.
// A taken request is held in the execute state until the output register is
// free or being drained; its result is then registered there. The block takes
// no new request until the previous one has completed.
// The next request is taken while an earlier result still waits in the
// output register; a stalled receiver holds that result and blocks only the
// completion of the following request, never drops or repeats one.
// Reset restores chunk_bytes to 64 and chunk_count to 256, empties the stack
// and reloads the untouched countdown, so chunks count-1 down to 0 go first.
// Registers: chunk_bytes at address 0, chunk_count at address 4. Write them
// only while no request is outstanding; pready is always high.
module fixed_chunk_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [fcpa_pkg::SIZE_W-1:0]   request_bytes,
  input  logic [fcpa_pkg::IDX_W-1:0]    free_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [fcpa_pkg::DATA_W-1:0]   pwdata,
  output logic [fcpa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import fcpa_pkg::*;

  fcpa_ctl_t         ctl;
  logic              cfg_we;
  logic [SIZE_W-1:0] chunk_bytes;
  logic [CNT_W-1:0]  chunk_count;

  // Register port decode.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_CHUNK_BYTES: prdata = DATA_W'(chunk_bytes);
      REG_CHUNK_COUNT: prdata = DATA_W'(chunk_count);
      default:         prdata = '0;
    endcase
  end

  fcpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  fcpa_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd           (cmd),
    .request_bytes (request_bytes),
    .free_index    (free_index),
    .cfg_we        (cfg_we),
    .cfg_sel       (paddr[2]),
    .cfg_wdata     (pwdata),
    .chunk_bytes   (chunk_bytes),
    .chunk_count   (chunk_count),
    .status        (status),
    .granted_index (granted_index)
  );

  // A taken request holds off the next one until it has completed.
  a_one_outstanding: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is still being worked on");

  // Only a successful allocate hands out a nonzero index.
  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (granted_index == '0))
    else $error("nonzero granted_index on a failed request");

  // A new result appears only from a request held by the controller.
  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result produced without a held request");

endmodule

// ===== verif/fixed_chunk_pool_allocator_test.sv =====
// Testbench for the fixed chunk pool allocator: free-list predictor, scoreboard and traffic.
`timescale 1ns / 1ps

module fixed_chunk_pool_allocator_test;
  import fcpa_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Byte addresses of the two configuration registers.
  localparam logic [ADDR_W-1:0] ADDR_CHUNK_BYTES = {REG_CHUNK_BYTES, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_CHUNK_COUNT = {REG_CHUNK_COUNT, 2'b00};

  localparam int LONG_HOLD   = 120;
  localparam int MAX_REPORTS = 10;

  typedef enum int {TR_MIXED, TR_FREES, TR_ALLOCS} traffic_t;
  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] grant;
  } pool_answer_t;

  // Tracks the free list and the answers still owed by the block.
  class free_list_scoreboard;
    logic [IDX_W-1:0]  link_mem [NUM_CHUNKS];
    logic [IDX_W-1:0]  top_chunk;
    bit                stack_filled;
    logic [CNT_W-1:0]  stack_depth;
    logic [CNT_W-1:0]  fresh_left;
    logic [SIZE_W-1:0] chunk_bytes;
    logic [CNT_W-1:0]  chunk_count;
    pool_answer_t      owed_answers[$];
    int                mismatches;

    function new();
      chunk_bytes = CHUNK_BYTES_RST;
      chunk_count = CHUNK_COUNT_RST;
      mismatches  = 0;
      reload();
    endfunction

    function int live_chunks();
      return (chunk_count > NUM_CHUNKS) ? NUM_CHUNKS : int'(chunk_count);
    endfunction

    // Drop the stack and restart the countdown of untouched chunks.
    function void reload();
      top_chunk    = '0;
      stack_filled = 1'b0;
      stack_depth  = '0;
      fresh_left   = CNT_W'(live_chunks());
    endfunction

    function void write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
      if (addr == ADDR_CHUNK_BYTES) begin
        chunk_bytes = value[SIZE_W-1:0];
      end else begin
        chunk_count = value[CNT_W-1:0];
      end
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction

    function void flag(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Apply one accepted request transaction and queue the answer it must produce.
    function void note_request(logic [1:0] op, logic [SIZE_W-1:0] nbytes,
                               logic [IDX_W-1:0] idx);
      pool_answer_t ans;
      ans = '0;
      ans.status = ST_OK;
      case (op)
        CMD_ALLOC: begin
          // The size check wins even over an empty pool.
          if (nbytes > chunk_bytes) begin
            ans.status = ST_TOO_BIG;
          end else if (stack_filled) begin
            ans.grant = top_chunk;
            top_chunk = link_mem[top_chunk];
            if (stack_depth != 0) stack_depth--;
            stack_filled = (stack_depth != 0);
          end else if (fresh_left != 0) begin
            fresh_left--;
            ans.grant = fresh_left[IDX_W-1:0];
          end else begin
            ans.status = ST_EMPTY;
          end
        end
        CMD_FREE: begin
          if (idx >= live_chunks()) begin
            ans.status = ST_RANGE;
          end else begin
            link_mem[idx] = top_chunk;
            top_chunk = idx;
            // The depth counter saturates, but the push still links in.
            if (stack_depth != LEN_MAX) stack_depth++;
            stack_filled = 1'b1;
          end
        end
        CMD_FREE_ALL: reload();
        default: ;
      endcase
      owed_answers.push_back(ans);
    endfunction

    // Compare one result transaction against the oldest owed answer.
    function void check_result(logic [1:0] st, logic [IDX_W-1:0] gi);
      pool_answer_t want;
      if (owed_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result transaction with none expected: status %0d, index %0d",
                   $time, st, gi);
        return;
      end
      want = owed_answers.pop_front();
      if (st !== want.status) flag("status", DATA_W'(want.status), DATA_W'(st));
      if (gi !== want.grant) flag("granted_index", DATA_W'(want.grant), DATA_W'(gi));
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = CMD_ALLOC;
  logic [SIZE_W-1:0]   request_bytes = '0;
  logic [IDX_W-1:0]    free_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic [IDX_W-1:0]    granted_index;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  free_list_scoreboard sb = new();
  int cur_bytes = CHUNK_BYTES_RST;
  int cur_count = CHUNK_COUNT_RST;
  int hold_requests = 0;
  int holds_done = 0;

  fixed_chunk_pool_allocator dut (.*);

  initial begin : clock_gen
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #400_000;
    $display("== FAIL ==");
    $finish;
  end

  // Both channels are sampled at the rising edge, before any drive takes effect.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(cmd, request_bytes, free_index);
      if (out_valid && out_ready) sb.check_result(status, granted_index);
    end
  end

  // Receiver: segments of steady, coin-flip and sparse acceptance, plus the long
  // hold-off that the stimulus asks for.
  initial begin : receiver
    int       seg_left;
    rx_mode_t mode;
    seg_left = 0;
    mode = RX_STEADY;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 48);
          mode = rx_mode_t'($urandom_range(0, 2));
        end
        seg_left--;
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one request transaction and return at the edge that accepts it.
  task automatic send_request(logic [1:0] op, logic [SIZE_W-1:0] nbytes,
                              logic [IDX_W-1:0] idx);
    bit taken;
    in_valid      <= 1'b1;
    cmd           <= op;
    request_bytes <= nbytes;
    free_index    <= idx;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering requests and wait until every owed answer has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write a register through its setup and access cycles, then read it back.
  task automatic program_reg(logic [ADDR_W-1:0] addr, int value);
    logic [DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // The write lands at this edge; the read setup follows directly.
    sb.write_reg(addr, DATA_W'(value));
    if (addr == ADDR_CHUNK_BYTES) cur_bytes = value;
    else cur_count = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== DATA_W'(value)) sb.flag("register readback", DATA_W'(value), readback);
  endtask

  // Random requests in bursts with random gaps. Mixed traffic is mostly
  // well-formed, with oversized allocations and stray indexes as noise.
  task automatic send_traffic(traffic_t kind, int count);
    int left;
    int burst;
    int gap;
    int roll;
    logic [1:0]        op;
    logic [SIZE_W-1:0] nbytes;
    logic [IDX_W-1:0]  idx;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        roll   = $urandom_range(0, 99);
        nbytes = SIZE_W'($urandom_range(0, cur_bytes));
        idx    = IDX_W'($urandom_range(0, cur_count - 1));
        op     = CMD_ALLOC;
        if (kind == TR_FREES || (kind == TR_MIXED && roll >= 50 && roll < 90))
          op = CMD_FREE;
        else if (kind == TR_MIXED && roll >= 90 && roll < 96)
          op = CMD_FREE_ALL;
        else if (kind == TR_MIXED && roll >= 96)
          op = CMD_UNUSED;
        if (kind == TR_MIXED && $urandom_range(0, 9) == 0)
          nbytes = SIZE_W'($urandom_range(0, 65535));
        if (kind == TR_MIXED && $urandom_range(0, 9) == 0)
          idx = IDX_W'($urandom_range(0, 255));
        send_request(op, nbytes, idx);
      end
      left -= burst;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) pause_sender(gap);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: size limit edges, every command, freeing an untouched chunk,
    // a double free and the unused command.
    send_request(CMD_ALLOC, 16'd64, 8'd0);
    send_request(CMD_ALLOC, 16'd65, 8'd0);
    send_request(CMD_ALLOC, 16'd0, 8'd255);
    send_request(CMD_ALLOC, 16'hFFFF, 8'd0);
    send_request(CMD_FREE, 16'd0, 8'd255);
    send_request(CMD_FREE, 16'hFFFF, 8'd0);
    send_request(CMD_ALLOC, 16'd1, 8'd0);
    send_request(CMD_ALLOC, 16'd1, 8'd0);
    send_request(CMD_UNUSED, 16'hFFFF, 8'hFF);
    send_request(CMD_FREE, 16'd0, 8'd254);
    send_request(CMD_FREE, 16'd0, 8'd254);
    send_request(CMD_ALLOC, 16'd0, 8'd0);
    send_request(CMD_ALLOC, 16'd0, 8'd0);
    send_request(CMD_ALLOC, 16'd0, 8'd0);
    send_request(CMD_FREE_ALL, 16'hFFFF, 8'hFF);
    send_request(CMD_ALLOC, 16'd64, 8'd0);
    drain();

    // Smallest settings. The count shrinks without a reload, so the range
    // check changes at once while the countdown keeps its old value.
    program_reg(ADDR_CHUNK_BYTES, 1);
    program_reg(ADDR_CHUNK_COUNT, 1);
    send_request(CMD_FREE, 16'd0, 8'd1);
    send_request(CMD_FREE, 16'd0, 8'd255);
    send_request(CMD_ALLOC, 16'd1, 8'd0);
    send_request(CMD_FREE_ALL, 16'd0, 8'd0);
    send_request(CMD_ALLOC, 16'd1, 8'd0);
    send_request(CMD_ALLOC, 16'd0, 8'd0);
    send_request(CMD_ALLOC, 16'd2, 8'd0);
    send_request(CMD_FREE, 16'd0, 8'd0);
    send_request(CMD_ALLOC, 16'd1, 8'd0);
    drain();

    // Largest settings, with a long receiver hold-off so the block backs up.
    program_reg(ADDR_CHUNK_BYTES, 65535);
    program_reg(ADDR_CHUNK_COUNT, 256);
    hold_requests++;
    send_traffic(TR_MIXED, 40);
    drain();

    // A small pool that runs dry often.
    program_reg(ADDR_CHUNK_BYTES, $urandom_range(1, 4096));
    program_reg(ADDR_CHUNK_COUNT, $urandom_range(2, 12));
    send_request(CMD_FREE_ALL, 16'd0, 8'd0);
    send_traffic(TR_MIXED, 40);
    drain();

    // Count changed in the middle of use.
    program_reg(ADDR_CHUNK_COUNT, $urandom_range(1, 256));
    send_traffic(TR_MIXED, 30);
    drain();

    // Push past the depth limit so the length counter saturates, then pop
    // a run of chunks back along the links.
    program_reg(ADDR_CHUNK_BYTES, $urandom_range(1, 65535));
    program_reg(ADDR_CHUNK_COUNT, 256);
    send_request(CMD_FREE_ALL, 16'd0, 8'd0);
    send_traffic(TR_FREES, int'(LEN_MAX) + 4);
    send_traffic(TR_ALLOCS, 70);
    drain();

    program_reg(ADDR_CHUNK_BYTES, $urandom_range(1, 65535));
    program_reg(ADDR_CHUNK_COUNT, $urandom_range(1, 256));
    send_traffic(TR_MIXED, 30);
    drain();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
